// ===== hdl/urp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urp_pkg
// Shared types and constants of the ultrasonic ranger with presence flag.
// ----------------------------------------------------------------------------
package urp_pkg;

	// Timebase: sample beats per millisecond and trigger pulse lengths
	localparam int TICKS_PER_MS = 1000;
	localparam int TRIG_LOW_US  = 5;
	localparam int TRIG_HIGH_US = 10;

	localparam int SUB_W  = $clog2(TICKS_PER_MS + 1);
	localparam int TSC_W  = 4;
	localparam int TIME_W = 32;
	localparam int DIST_W = 16;
	localparam int REM_W  = 9;

	// Distance is ((w / 2) * CM_NUM) / CM_DEN, saturated to DIST_W bits
	localparam int CM_NUM = 100;
	localparam int CM_DEN = 291;
	// Smallest half width whose distance no longer fits in DIST_W bits
	localparam longint SAT_HALF  = ((longint'(1) << DIST_W) * CM_DEN + CM_NUM - 1) / CM_NUM;
	localparam longint SAT_WIDTH = 2 * SAT_HALF;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TLOW  = 3'd1,
		PH_THIGH = 3'd2,
		PH_RISE  = 3'd3,
		PH_FALL  = 3'd4,
		PH_READY = 3'd5
	} urp_phase_t;

	typedef enum logic [7:0] {
		CFG_INTERVAL_MS     = 8'd0,
		CFG_MIN_DISTANCE_CM = 8'd1,
		CFG_HOLD_TIMEOUT_MS = 8'd2,
		CFG_PRESENCE_ENABLE = 8'd3
	} urp_cfg_idx_t;

	typedef struct packed {
		logic [15:0] interval_ms;
		logic [15:0] min_distance_cm;
		logic [23:0] hold_timeout_ms;
		logic        presence_enable;
	} urp_cfg_t;

	typedef struct packed {
		logic echo_level;
		logic read_ack;
	} urp_sample_t;

	typedef struct packed {
		logic              pin_drive_enable;
		logic              trigger_level;
		logic [DIST_W-1:0] distance_cm;
		logic              distance_ready;
		logic              measuring;
		logic              presence;
	} urp_result_t;

	// Echo width tracker control
	typedef struct packed {
		logic start;
		logic advance;
	} urp_trk_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/urp_timebase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urp_timebase
// Millisecond counter, advanced every TICKS_PER_MS processed sample beats.
// ----------------------------------------------------------------------------
module urp_timebase (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        tick,
	output logic [urp_pkg::TIME_W-1:0]       ms_time
);

	logic [urp_pkg::SUB_W-1:0]  sub_ms_q;
	logic [urp_pkg::TIME_W-1:0] ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_ms_q <= '0;
			ms_q     <= '0;
		end else if (tick) begin
			if (sub_ms_q == urp_pkg::SUB_W'(urp_pkg::TICKS_PER_MS - 1)) begin
				sub_ms_q <= '0;
				ms_q     <= ms_q + 1'b1;
			end else begin
				sub_ms_q <= sub_ms_q + 1'b1;
			end
		end
	end

	assign ms_time = ms_q;

endmodule
`default_nettype wire

// ===== hdl/urp_width.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urp_width
// Echo pulse width tracker. Counts the width and keeps the distance
// quotient and remainder up to date, one half-width step at a time.
// ----------------------------------------------------------------------------
module urp_width (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire urp_pkg::urp_trk_ctl_t         ctl,
	output logic [urp_pkg::DIST_W-1:0]         distance
);

	logic [urp_pkg::TIME_W-1:0] width_q;
	logic [urp_pkg::DIST_W-1:0] quot_q;
	logic [urp_pkg::REM_W-1:0]  rem_q;

	logic [urp_pkg::TIME_W-1:0] width_inc;
	logic [urp_pkg::REM_W:0]    rem_sum;

	assign width_inc = width_q + 1'b1;
	assign rem_sum   = {1'b0, rem_q} + (urp_pkg::REM_W+1)'(urp_pkg::CM_NUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (ctl.start) begin
			// rise beat: width is one after this beat
			width_q <= urp_pkg::TIME_W'(1);
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (ctl.advance) begin
			width_q <= width_inc;
			if (width_inc == '0) begin
				quot_q <= '0;
				rem_q  <= '0;
			end else if (width_q[0]) begin
				// half width grows by one: add the numerator step
				if (rem_sum >= (urp_pkg::REM_W+1)'(urp_pkg::CM_DEN)) begin
					rem_q <= urp_pkg::REM_W'(rem_sum - (urp_pkg::REM_W+1)'(urp_pkg::CM_DEN));
					if (quot_q != '1) begin
						quot_q <= quot_q + 1'b1;
					end
				end else begin
					rem_q <= urp_pkg::REM_W'(rem_sum);
				end
			end
		end
	end

	assign distance = ({32'd0, width_q} >= 64'(urp_pkg::SAT_WIDTH)) ? '1 : quot_q;

endmodule
`default_nettype wire

// ===== hdl/urp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urp_ctrl
// Trigger and measurement sequencer with presence tracking. Updates its
// state once per processed beat and forms that beat's result.
// ----------------------------------------------------------------------------
module urp_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire urp_pkg::urp_sample_t          sample,
	input  wire urp_pkg::urp_cfg_t             cfg,
	input  wire logic [urp_pkg::TIME_W-1:0]    ms_time,
	input  wire logic [urp_pkg::DIST_W-1:0]    distance,
	output urp_pkg::urp_trk_ctl_t              trk_ctl,
	output urp_pkg::urp_result_t               result
);

	urp_pkg::urp_phase_t        phase_q, phase_cur, phase_n;
	logic [urp_pkg::TSC_W-1:0]  tsc_q, tsc_n, tsc_inc;
	logic [urp_pkg::TIME_W-1:0] last_trig_q, last_trig_n;
	logic [urp_pkg::TIME_W-1:0] pres_set_q, pres_set_n;
	logic [urp_pkg::DIST_W-1:0] held_q, held_n;
	logic                       pres_q, pres_n;
	logic                       prev_echo_q;
	logic                       rise, fall;
	logic                       interval_due, hold_expired;

	assign rise    = sample.echo_level && !prev_echo_q;
	assign fall    = !sample.echo_level && prev_echo_q;
	assign tsc_inc = tsc_q + 1'b1;

	assign interval_due = (ms_time - last_trig_q) >= {16'd0, cfg.interval_ms};
	assign hold_expired = (ms_time - pres_set_q) > {8'd0, cfg.hold_timeout_ms};

	always_comb begin
		phase_cur   = phase_q;
		tsc_n       = tsc_q;
		last_trig_n = last_trig_q;
		pres_set_n  = pres_set_q;
		held_n      = held_q;
		pres_n      = pres_q;
		trk_ctl     = '0;

		// acknowledge first, then act on the phase
		if (phase_cur == urp_pkg::PH_READY && sample.read_ack) begin
			phase_cur = urp_pkg::PH_IDLE;
		end
		phase_n = phase_cur;

		unique case (phase_cur)
			urp_pkg::PH_TLOW: begin
				if (tsc_inc >= urp_pkg::TSC_W'(urp_pkg::TRIG_LOW_US)) begin
					phase_n = urp_pkg::PH_THIGH;
					tsc_n   = '0;
				end else begin
					tsc_n = tsc_inc;
				end
			end
			urp_pkg::PH_THIGH: begin
				if (tsc_inc >= urp_pkg::TSC_W'(urp_pkg::TRIG_HIGH_US)) begin
					phase_n = urp_pkg::PH_RISE;
					tsc_n   = '0;
				end else begin
					tsc_n = tsc_inc;
				end
			end
			urp_pkg::PH_RISE: begin
				if (rise) begin
					phase_n       = urp_pkg::PH_FALL;
					trk_ctl.start = fire;
				end
			end
			urp_pkg::PH_FALL: begin
				trk_ctl.advance = fire;
				if (fall) begin
					phase_n = urp_pkg::PH_READY;
					held_n  = distance;
					if (cfg.presence_enable) begin
						if (distance <= cfg.min_distance_cm) begin
							pres_set_n = ms_time;
							pres_n     = 1'b1;
						end else if (hold_expired) begin
							pres_n = 1'b0;
						end
					end
				end
			end
			default: begin
				// idle or ready: start a new trigger once the interval is up
				if (interval_due) begin
					last_trig_n = ms_time;
					phase_n     = urp_pkg::PH_TLOW;
					tsc_n       = '0;
				end
			end
		endcase

		result.pin_drive_enable = (phase_n == urp_pkg::PH_TLOW) ||
		                          (phase_n == urp_pkg::PH_THIGH);
		result.trigger_level    = (phase_n == urp_pkg::PH_THIGH);
		result.distance_cm      = held_n;
		result.distance_ready   = (phase_n == urp_pkg::PH_READY);
		result.measuring        = (phase_n == urp_pkg::PH_RISE) ||
		                          (phase_n == urp_pkg::PH_FALL);
		result.presence         = pres_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= urp_pkg::PH_IDLE;
			tsc_q       <= '0;
			last_trig_q <= '0;
			pres_set_q  <= '0;
			held_q      <= '0;
			pres_q      <= 1'b0;
			prev_echo_q <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_n;
			tsc_q       <= tsc_n;
			last_trig_q <= last_trig_n;
			pres_set_q  <= pres_set_n;
			held_q      <= held_n;
			pres_q      <= pres_n;
			prev_echo_q <= sample.echo_level;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_ranger_presence_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_ranger_presence_unit
// Ultrasonic echo ranger: trigger pulse generation, echo width to distance
// conversion and a presence flag with hold time. One sample beat per
// microsecond in, one result beat per sample out.
//
//   channel  signals                              beat
//   sample   sample_valid / sample_stall / sample  echo level, read ack
//   result   result_valid / result_stall / result  pin drive, distance, flags
//   cfg      cfg_valid / cfg_ready / cfg_index     one register write
//
// From sample accept to result valid: input register, then the sequencer
// logic into the result register. One sample per cycle sustained while
// the result does not stall; sequencer state updates with each result.
// Reset puts the sequencer in idle, zeroes all timers and loads the
// register defaults. A stalled result holds the input register, and the
// sample channel stalls only when both registers are occupied.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_presence_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire urp_pkg::urp_sample_t   sample,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output urp_pkg::urp_result_t        result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [7:0]             cfg_index,
	input  wire logic [23:0]            cfg_data
);

	urp_pkg::urp_cfg_t                  cfg_q;
	urp_pkg::urp_sample_t               sample_s1;
	logic                               valid_s1;
	urp_pkg::urp_result_t               result_s2;
	logic                               valid_s2;
	urp_pkg::urp_result_t               result_d;
	urp_pkg::urp_trk_ctl_t              trk_ctl;
	logic [urp_pkg::TIME_W-1:0]         ms_time;
	logic [urp_pkg::DIST_W-1:0]         distance;
	logic                               fire;
	logic                               take_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms     <= 16'd60;
			cfg_q.min_distance_cm <= '0;
			cfg_q.hold_timeout_ms <= '0;
			cfg_q.presence_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				urp_pkg::CFG_INTERVAL_MS:     cfg_q.interval_ms     <= cfg_data[15:0];
				urp_pkg::CFG_MIN_DISTANCE_CM: cfg_q.min_distance_cm <= cfg_data[15:0];
				urp_pkg::CFG_HOLD_TIMEOUT_MS: cfg_q.hold_timeout_ms <= cfg_data;
				urp_pkg::CFG_PRESENCE_ENABLE: cfg_q.presence_enable <= cfg_data[0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Advance the input register into the result register when it is free
	assign fire         = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !fire;
	assign take_in      = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= sample;
		end
		if (fire) begin
			result_s2 <= result_d;
		end
	end

	urp_timebase u_timebase (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (fire),
		.ms_time (ms_time)
	);

	urp_width u_width (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (trk_ctl),
		.distance (distance)
	);

	urp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.sample   (sample_s1),
		.cfg      (cfg_q),
		.ms_time  (ms_time),
		.distance (distance),
		.trk_ctl  (trk_ctl),
		.result   (result_d)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
`default_nettype wire
